// ----- src/rwag_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwag_pkg
// Shared widths, register indexes, error codes and types of the rotated
// window address generator.
// ----------------------------------------------------------------------------
package rwag_pkg;

	localparam int MAX_DIM   = 4096;
	localparam int FRAC_BITS = 8;
	localparam int POS_FRAC  = 17;

	localparam int CW    = 21;              // coordinate register width
	localparam int DW    = 13;              // dimension register width
	localparam int COLW  = 13;
	localparam int ROWW  = 12;
	localparam int SRCW  = 24;
	localparam int DSTW  = 25;
	localparam int LENW  = 13;
	localparam int ERRW  = 2;
	localparam int ADDRW = 3;

	localparam int DXW   = CW + 1;          // signed line delta
	localparam int SQW   = 2 * DXW + 16;    // squared length shifted by 16
	localparam int ROOTW = SQW / 2;
	localparam int NUMW  = CW + 24;         // |delta| << 24
	localparam int DENW  = ROOTW;
	localparam int UW    = 18;              // signed q1.16 direction
	localparam int PW    = 34;              // signed q.17 position
	localparam int XW    = PW - POS_FRAC;   // truncated position
	localparam int PIXW  = 12;              // in-image pixel coordinate

	localparam logic [ADDRW-1:0] REG_START_X      = 3'd0;
	localparam logic [ADDRW-1:0] REG_START_Y      = 3'd1;
	localparam logic [ADDRW-1:0] REG_END_X        = 3'd2;
	localparam logic [ADDRW-1:0] REG_END_Y        = 3'd3;
	localparam logic [ADDRW-1:0] REG_WINDOW_WIDTH = 3'd4;
	localparam logic [ADDRW-1:0] REG_IMAGE_WIDTH  = 3'd5;
	localparam logic [ADDRW-1:0] REG_IMAGE_HEIGHT = 3'd6;

	localparam logic [ERRW-1:0] ERR_OK    = 2'd0;
	localparam logic [ERRW-1:0] ERR_RANGE = 2'd1;
	localparam logic [ERRW-1:0] ERR_ZERO  = 2'd2;

	typedef struct packed {
		logic                   busy;
		logic [ERRW-1:0]        err;
		logic [LENW-1:0]        len;
		logic signed [UW-1:0]   ux;
		logic signed [UW-1:0]   uy;
		logic signed [PW-1:0]   base_x;
		logic signed [PW-1:0]   base_y;
		logic [DW-1:0]          nx;
		logic [DW-1:0]          ny;
		logic [DW-1:0]          ww;
	} cfg_res_t;

	function automatic logic [DW-1:0] sat_dim(input logic [DW-1:0] v);
		return (v > DW'(MAX_DIM)) ? DW'(MAX_DIM) : v;
	endfunction

endpackage
`default_nettype wire

// ----- src/rwag_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwag_ifs
// Valid/ready channels: pixel input, result output and register writes.
// ----------------------------------------------------------------------------
interface rwag_pix_if;
	import rwag_pkg::*;
	logic            valid;
	logic            ready;
	logic [COLW-1:0] out_col;
	logic [ROWW-1:0] out_row;
	modport source (output valid, out_col, out_row, input ready);
	modport sink   (input valid, out_col, out_row, output ready);
endinterface

interface rwag_res_if;
	import rwag_pkg::*;
	logic            valid;
	logic            ready;
	logic [SRCW-1:0] src_index;
	logic [DSTW-1:0] dst_index;
	logic            copy_valid;
	logic [LENW-1:0] window_length;
	logic [ERRW-1:0] error_code;
	modport source (output valid, src_index, dst_index, copy_valid, window_length,
		error_code, input ready);
	modport sink   (input valid, src_index, dst_index, copy_valid, window_length,
		error_code, output ready);
endinterface

interface rwag_cfg_if;
	import rwag_pkg::*;
	logic             valid;
	logic             ready;
	logic [ADDRW-1:0] addr;
	logic [CW-1:0]    data;
	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// ----- src/rwag_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwag_isqrt
// Bit-pair integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module rwag_isqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [rwag_pkg::SQW-1:0]    value,
	output logic                             done,
	output logic [rwag_pkg::ROOTW-1:0]       root
);
	import rwag_pkg::*;

	localparam int STEPS = SQW / 2;
	localparam int CNTW  = $clog2(STEPS);

	logic [SQW-1:0]  v_q, res_q, bit_q, sum;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q, ge;

	assign sum  = res_q + bit_q;
	assign ge   = v_q >= sum;
	assign root = res_q[ROOTW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done   <= 1'b0;
			cnt_q  <= CNTW'(STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done   <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			res_q <= '0;
			bit_q <= SQW'(1) << (SQW - 2);
		end else if (busy_q) begin
			if (ge) begin
				v_q   <= v_q - sum;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule
`default_nettype wire

// ----- src/rwag_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwag_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rwag_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [rwag_pkg::NUMW-1:0]  num,
	input  wire logic [rwag_pkg::DENW-1:0]  den,
	output logic                            done,
	output logic [rwag_pkg::NUMW-1:0]       quo
);
	import rwag_pkg::*;

	localparam int CNTW = $clog2(NUMW);

	logic [DENW-1:0] rem_q, den_q;
	logic [NUMW-1:0] quo_q;
	logic [DENW:0]   trial, diff;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q, ge;

	// numerator bits leave the top of quo_q as quotient bits enter below
	assign trial = {rem_q, quo_q[NUMW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done   <= 1'b0;
			cnt_q  <= CNTW'(NUMW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done   <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
			quo_q <= {quo_q[NUMW-2:0], ge};
		end
	end

endmodule
`default_nettype wire

// ----- src/rwag_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rwag_cfg
// Register file and setup sequencer: length, direction, window corner and
// error code, recomputed after reset and after every register write.
// ----------------------------------------------------------------------------
module rwag_cfg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	rwag_cfg_if.sink           cfg,
	output rwag_pkg::cfg_res_t res
);
	import rwag_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DELTA = 3'd1;
	localparam logic [2:0] ST_SQUARE = 3'd2;
	localparam logic [2:0] ST_L2 = 3'd3;
	localparam logic [2:0] ST_ROOT = 3'd4;
	localparam logic [2:0] ST_DIV = 3'd5;
	localparam logic [2:0] ST_SCALE = 3'd6;
	localparam logic [2:0] ST_FIN = 3'd7;

	logic [2:0]             state_q;
	logic [CW-1:0]          sx_q, sy_q, ex_q, ey_q;
	logic [DW-1:0]          ww_raw_q, iw_q, ih_q;
	logic signed [DXW-1:0]  dx_q, dy_q;
	logic [2*DXW-1:0]       sqx_q, sqy_q;
	logic [ROOTW-1:0]       s_q;
	logic signed [UW-1:0]   ux_q, uy_q;
	logic signed [UW+DW:0]  prodx_q, prody_q;
	logic [ERRW-1:0]        err_q;
	logic [LENW-1:0]        len_q;
	logic signed [PW-1:0]   base_x_q, base_y_q;
	logic [DW-1:0]          nx_q, ny_q, ww_q;

	logic                   wr;
	logic [DW-1:0]          nx_c, ny_c, ww_c;
	logic [CW-1:0]          xlim, ylim;
	logic                   range_bad;
	logic [LENW-1:0]        len_c;
	logic [SQW-1:0]         l2_shift;
	logic                   root_start, root_done, div_start, divx_done, divy_done;
	logic [ROOTW-1:0]       root;
	logic [CW-1:0]          magx, magy;
	logic [DXW-1:0]         negx, negy;
	logic [NUMW-1:0]        qx, qy;
	logic signed [UW-1:0]   qxs, qys;
	logic signed [2*DXW-1:0] sqx_c, sqy_c;

	assign wr        = cfg.valid && cfg.ready;
	assign cfg.ready = 1'b1;

	assign nx_c      = sat_dim(iw_q);
	assign ny_c      = sat_dim(ih_q);
	assign ww_c      = sat_dim(ww_raw_q);
	assign xlim      = CW'({nx_c, {FRAC_BITS{1'b0}}});
	assign ylim      = CW'({ny_c, {FRAC_BITS{1'b0}}});
	assign range_bad = (sx_q > xlim) || (ex_q > xlim) || (sy_q > ylim) || (ey_q > ylim);
	// floor of the pixel length is the q.16 root shifted down
	assign len_c     = s_q[LENW+15:16];

	assign l2_shift   = {SQW'(sqx_q + sqy_q)} << 16;
	assign root_start = (state_q == ST_L2);
	assign div_start  = (state_q == ST_ROOT) && root_done;

	// full-width signed squares
	assign sqx_c = dx_q * dx_q;
	assign sqy_c = dy_q * dy_q;

	assign negx = -dx_q;
	assign negy = -dy_q;
	assign magx = dx_q[DXW-1] ? negx[CW-1:0] : dx_q[CW-1:0];
	assign magy = dy_q[DXW-1] ? negy[CW-1:0] : dy_q[CW-1:0];
	assign qxs  = $signed(qx[UW-1:0]);
	assign qys  = $signed(qy[UW-1:0]);

	rwag_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.value  (l2_shift),
		.done   (root_done),
		.root   (root)
	);

	rwag_div u_divx (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({magx, 24'd0}),
		.den    (root),
		.done   (divx_done),
		.quo    (qx)
	);

	rwag_div u_divy (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({magy, 24'd0}),
		.den    (root),
		.done   (divy_done),
		.quo    (qy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q     <= '0;
			sy_q     <= '0;
			ex_q     <= '0;
			ey_q     <= '0;
			ww_raw_q <= DW'(1);
			iw_q     <= DW'(MAX_DIM);
			ih_q     <= DW'(MAX_DIM);
			state_q  <= ST_DELTA;
		end else begin
			if (wr) begin
				case (cfg.addr)
					REG_START_X:      sx_q <= cfg.data;
					REG_START_Y:      sy_q <= cfg.data;
					REG_END_X:        ex_q <= cfg.data;
					REG_END_Y:        ey_q <= cfg.data;
					REG_WINDOW_WIDTH: ww_raw_q <= cfg.data[DW-1:0];
					REG_IMAGE_WIDTH:  iw_q <= cfg.data[DW-1:0];
					REG_IMAGE_HEIGHT: ih_q <= cfg.data[DW-1:0];
					default: ;
				endcase
			end
			// any write restarts the setup sequence
			if (wr) begin
				state_q <= ST_DELTA;
			end else begin
				case (state_q)
					ST_DELTA:  state_q <= ST_SQUARE;
					ST_SQUARE: state_q <= ST_L2;
					ST_L2:     state_q <= ST_ROOT;
					ST_ROOT:   if (root_done) state_q <= ST_DIV;
					ST_DIV:    if (divx_done && divy_done) state_q <= ST_SCALE;
					ST_SCALE:  state_q <= ST_FIN;
					ST_FIN:    state_q <= ST_IDLE;
					default:   state_q <= ST_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_DELTA: begin
				dx_q <= $signed({1'b0, ex_q}) - $signed({1'b0, sx_q});
				dy_q <= $signed({1'b0, ey_q}) - $signed({1'b0, sy_q});
			end
			ST_SQUARE: begin
				sqx_q <= $unsigned(sqx_c);
				sqy_q <= $unsigned(sqy_c);
			end
			ST_ROOT: if (root_done) s_q <= root;
			ST_DIV: begin
				ux_q <= dx_q[DXW-1] ? -qxs : qxs;
				uy_q <= dy_q[DXW-1] ? -qys : qys;
			end
			ST_SCALE: begin
				prodx_q <= uy_q * $signed({1'b0, ww_c});
				prody_q <= ux_q * $signed({1'b0, ww_c});
			end
			ST_FIN: begin
				base_x_q <= $signed(PW'(sx_q) << (POS_FRAC - FRAC_BITS)) + PW'(prodx_q);
				base_y_q <= $signed(PW'(sy_q) << (POS_FRAC - FRAC_BITS)) - PW'(prody_q);
				nx_q     <= nx_c;
				ny_q     <= ny_c;
				ww_q     <= ww_c;
				len_q    <= range_bad ? '0 : len_c;
				err_q    <= range_bad ? ERR_RANGE : ((len_c == '0) ? ERR_ZERO : ERR_OK);
			end
			default: ;
		endcase
	end

	assign res.busy   = (state_q != ST_IDLE);
	assign res.err    = err_q;
	assign res.len    = len_q;
	assign res.ux     = ux_q;
	assign res.uy     = uy_q;
	assign res.base_x = base_x_q;
	assign res.base_y = base_y_q;
	assign res.nx     = nx_q;
	assign res.ny     = ny_q;
	assign res.ww     = ww_q;

endmodule
`default_nettype wire

// ----- src/rotated_window_address_gen_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_window_address_gen_unit
// Nearest-neighbor source address generator for a window rotated along a
// configured line: four-stage pixel pipeline fed by a setup sequencer.
// ----------------------------------------------------------------------------
//  channel   dir  fields
//  cfg       in   addr, data (register write)
//  pix_in    in   out_col, out_row
//  res_out   out  src_index, dst_index, copy_valid, window_length, error_code
//
//  one item per cycle while res_out.ready is high and setup is idle
//  after reset or any register write the setup sequencer runs its delta, square,
//  length, root, divide, scale and finish steps with pix_in.ready low
//  each stage holds its item under a stall and takes a new one when freed
//  reset clears the valid bits and loads register reset values
// ----------------------------------------------------------------------------
module rotated_window_address_gen_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	rwag_cfg_if.sink  cfg,
	rwag_pix_if.sink  pix_in,
	rwag_res_if.source res_out
);
	import rwag_pkg::*;

	cfg_res_t cr;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4, take;

	logic [COLW-1:0]            col_s1;
	logic [ROWW-1:0]            row_s1;
	logic signed [COLW+UW:0]    cux_s1, ruy_s1, cuy_s1, rux_s1;
	logic [LENW+ROWW-1:0]       lrow_s1;

	logic signed [PW-1:0]       px_s2, py_s2;
	logic [DSTW-1:0]            dst_s2;
	logic                       win_s2;

	logic [PIXW-1:0]            x_s3, y_s3;
	logic [DSTW-1:0]            dst_s3;
	logic                       ok_s3;

	logic [SRCW-1:0]            src_s4;
	logic [DSTW-1:0]            dst_s4;
	logic                       ok_s4;

	logic signed [PW-1:0]       adjx, adjy;
	logic signed [XW-1:0]       xi, yi;
	logic                       x_in, y_in;
	logic [DW+PIXW-1:0]         nyprod;

	rwag_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.res    (cr)
	);

	assign rdy4 = !v_s4 || res_out.ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign pix_in.ready = rdy1 && !cr.busy;
	assign take = pix_in.valid && pix_in.ready;

	// truncate toward zero: bias negative positions before the shift
	assign adjx = px_s2 + (px_s2[PW-1] ? PW'((1 << POS_FRAC) - 1) : PW'(0));
	assign adjy = py_s2 + (py_s2[PW-1] ? PW'((1 << POS_FRAC) - 1) : PW'(0));
	assign xi   = adjx[PW-1:POS_FRAC];
	assign yi   = adjy[PW-1:POS_FRAC];
	assign x_in = !xi[XW-1] && (xi[XW-2:0] < (XW-1)'(cr.nx));
	assign y_in = !yi[XW-1] && (yi[XW-2:0] < (XW-1)'(cr.ny));

	assign nyprod = cr.nx * y_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= take;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			col_s1  <= pix_in.out_col;
			row_s1  <= pix_in.out_row;
			cux_s1  <= $signed({1'b0, pix_in.out_col}) * cr.ux;
			cuy_s1  <= $signed({1'b0, pix_in.out_col}) * cr.uy;
			ruy_s1  <= $signed({2'b0, pix_in.out_row}) * cr.uy;
			rux_s1  <= $signed({2'b0, pix_in.out_row}) * cr.ux;
			lrow_s1 <= cr.len * pix_in.out_row;
		end
		if (rdy2) begin
			px_s2  <= cr.base_x + (PW'(cux_s1 - ruy_s1) <<< 1);
			py_s2  <= cr.base_y + (PW'(cuy_s1 + rux_s1) <<< 1);
			dst_s2 <= DSTW'(col_s1) + DSTW'(lrow_s1);
			win_s2 <= (col_s1 < cr.len) && ({1'b0, row_s1} < cr.ww);
		end
		if (rdy3) begin
			x_s3   <= xi[PIXW-1:0];
			y_s3   <= yi[PIXW-1:0];
			dst_s3 <= dst_s2;
			ok_s3  <= (cr.err == ERR_OK) && win_s2 && x_in && y_in;
		end
		if (rdy4) begin
			src_s4 <= ok_s3 ? (SRCW'(x_s3) + SRCW'(nyprod)) : '0;
			dst_s4 <= ok_s3 ? dst_s3 : '0;
			ok_s4  <= ok_s3;
		end
	end

	assign res_out.valid         = v_s4;
	assign res_out.src_index     = src_s4;
	assign res_out.dst_index     = dst_s4;
	assign res_out.copy_valid    = ok_s4;
	assign res_out.window_length = cr.len;
	assign res_out.error_code    = cr.err;

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cr.busy |-> !pix_in.ready)
		else $error("item taken during setup");

	a_err_nocopy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_out.valid && res_out.error_code != ERR_OK) |-> !res_out.copy_valid)
		else $error("copy flagged on error");

	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_out.valid && !res_out.copy_valid) |->
		(res_out.src_index == '0 && res_out.dst_index == '0))
		else $error("skipped item carries an index");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> v_s1)
		else $error("accepted item lost at entry");

endmodule
`default_nettype wire

// ----- sim/rotated_window_address_gen_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_window_address_gen_unit_tb
// Self-checking bench for the rotated window address generator: register
// settings are applied while the unit is idle, pixel coordinates are streamed
// with random gaps and output stalls, and every result is checked field by
// field against a table entry or a fixed-point rotated nearest-neighbor model.
// ----------------------------------------------------------------------------
module rotated_window_address_gen_unit_tb;
	import rwag_pkg::*;

	typedef struct packed {
		logic [SRCW-1:0] src;
		logic [DSTW-1:0] dst;
		logic            cp;
		logic [LENW-1:0] len;
		logic [ERRW-1:0] err;
	} pix_res_t;

	typedef struct {
		logic [CW-1:0] sx, sy, ex, ey;
		logic [DW-1:0] ww, nw, nh;
	} geom_t;

	typedef struct {
		int              phase;
		logic [COLW-1:0] col;
		logic [ROWW-1:0] row;
		bit              fixed;
		pix_res_t        exp;
	} stim_row_t;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 300;

	logic clk;
	logic arst_n;

	rwag_cfg_if cfg ();
	rwag_pix_if pix ();
	rwag_res_if res ();

	rotated_window_address_gen_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg.sink),
		.pix_in  (pix.sink),
		.res_out (res.source)
	);

	geom_t     geo;
	pix_res_t  pending_q[$];
	stim_row_t stim_tbl[$];
	geom_t     phase_geo[$];
	int        n_fail, n_in, n_out, n_copy, n_err, n_cfg, n_phase;
	int        idle_cycles;
	bit        stim_done;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// integer square root, floor
	function automatic longint unsigned floor_root(input longint unsigned v);
		longint unsigned acc, one, rem;
		acc = 0;
		rem = v;
		one = 64'd1 << 62;
		while (one > rem) one = one >> 2;
		while (one != 0) begin
			if (rem >= acc + one) begin
				rem = rem - (acc + one);
				acc = (acc >> 1) + one;
			end else begin
				acc = acc >> 1;
			end
			one = one >> 2;
		end
		return acc;
	endfunction

	function automatic longint unsigned clamp_dim(input logic [DW-1:0] v);
		return (v > MAX_DIM) ? MAX_DIM : longint'(v);
	endfunction

	function automatic pix_res_t map_pixel(input logic [COLW-1:0] col,
			input logic [ROWW-1:0] row);
		pix_res_t        r;
		longint unsigned nx, ny, w, xlim, ylim, sq, len;
		longint          dx, dy, s, ux, uy, px, py, xi, yi, c, rw;
		r = '0;
		nx = clamp_dim(geo.nw);
		ny = clamp_dim(geo.nh);
		w = clamp_dim(geo.ww);
		xlim = nx << FRAC_BITS;
		ylim = ny << FRAC_BITS;
		if (geo.sx > xlim || geo.ex > xlim || geo.sy > ylim || geo.ey > ylim) begin
			r.err = ERR_RANGE;
			return r;
		end
		dx = longint'(geo.ex) - longint'(geo.sx);
		dy = longint'(geo.ey) - longint'(geo.sy);
		sq = dx * dx + dy * dy;
		len = floor_root(sq) >> FRAC_BITS;
		r.len = len[LENW-1:0];
		if (len == 0) begin
			r.err = ERR_ZERO;
			return r;
		end
		r.err = ERR_OK;
		s = floor_root(sq << 16);
		// signed division truncates toward zero
		ux = (dx * (64'sd1 <<< 24)) / s;
		uy = (dy * (64'sd1 <<< 24)) / s;
		c = longint'(col);
		rw = longint'(row);
		px = (longint'(geo.sx) <<< (POS_FRAC - FRAC_BITS)) + uy * longint'(w)
			+ 2 * (c * ux - rw * uy);
		py = (longint'(geo.sy) <<< (POS_FRAC - FRAC_BITS)) - ux * longint'(w)
			+ 2 * (c * uy + rw * ux);
		xi = px / (64'sd1 <<< POS_FRAC);
		yi = py / (64'sd1 <<< POS_FRAC);
		if (col < len && row < w && xi >= 0 && yi >= 0 && xi < nx && yi < ny) begin
			r.cp = 1'b1;
			r.src = SRCW'(longint'(xi) + longint'(nx) * yi);
			r.dst = DSTW'(longint'(col) + longint'(len) * longint'(row));
		end
		return r;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic write_reg(input logic [ADDRW-1:0] idx, input logic [CW-1:0] val);
		cfg.valid <= 1'b1;
		cfg.addr <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		n_cfg++;
	endtask

	task automatic apply_geom(input geom_t g);
		pix.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		write_reg(REG_START_X, g.sx);
		write_reg(REG_START_Y, g.sy);
		write_reg(REG_END_X, g.ex);
		write_reg(REG_END_Y, g.ey);
		write_reg(REG_WINDOW_WIDTH, CW'(g.ww));
		write_reg(REG_IMAGE_WIDTH, CW'(g.nw));
		write_reg(REG_IMAGE_HEIGHT, CW'(g.nh));
		cfg.valid <= 1'b0;
		geo = g;
		n_phase++;
	endtask

	task automatic send_pixel(input logic [COLW-1:0] col, input logic [ROWW-1:0] row,
			input bit fixed, input pix_res_t exp);
		int g;
		g = gap_len();
		if (g > 0) begin
			pix.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.out_col <= col;
		pix.out_row <= row;
		@(posedge clk);
		while (!pix.ready) @(posedge clk);
		pending_q.push_back(fixed ? exp : map_pixel(col, row));
		n_in++;
	endtask

	task automatic rand_geom(output geom_t g);
		int p;
		longint unsigned nx, ny;
		p = $urandom_range(0, 99);
		g.nw = (p < 70) ? DW'($urandom_range(1, 64)) : DW'($urandom);
		g.nh = (p < 70) ? DW'($urandom_range(1, 64)) : DW'($urandom);
		if ($urandom_range(0, 29) == 0) g.nh = '0;
		g.ww = ($urandom_range(0, 9) < 8) ? DW'($urandom_range(1, 24)) : DW'($urandom);
		nx = clamp_dim(g.nw) << FRAC_BITS;
		ny = clamp_dim(g.nh) << FRAC_BITS;
		g.sx = CW'($urandom_range(0, int'(nx)));
		g.sy = CW'($urandom_range(0, int'(ny)));
		g.ex = CW'($urandom_range(0, int'(nx)));
		g.ey = CW'($urandom_range(0, int'(ny)));
		if (p >= 90) begin
			// full-width coordinates, mostly out of range
			g.sx = CW'($urandom);
			g.ey = CW'($urandom);
		end else if (p >= 84) begin
			// sub-pixel line
			g.ex = (g.sx > 100) ? g.sx - CW'($urandom_range(0, 100)) : g.sx;
			g.ey = g.sy;
		end
	endtask

	// result side: random stalls plus one long hold-off
	initial begin
		int  s;
		bit  held;
		held = 1'b0;
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && n_in > 350) begin
				held = 1'b1;
				res.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			s = gap_len();
			if (s > 0) begin
				res.ready <= 1'b0;
				repeat (s) @(posedge clk);
			end
			res.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// result checker
	always @(posedge clk) begin
		pix_res_t e;
		if (arst_n && res.valid && res.ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: result with no item pending", $time);
				n_fail++;
			end else begin
				e = pending_q.pop_front();
				n_out++;
				if (res.copy_valid) n_copy++;
				if (res.error_code != ERR_OK) n_err++;
				if (res.src_index !== e.src) begin
					$display("%0t: src_index exp %0d got %0d", $time, e.src, res.src_index);
					n_fail++;
				end
				if (res.dst_index !== e.dst) begin
					$display("%0t: dst_index exp %0d got %0d", $time, e.dst, res.dst_index);
					n_fail++;
				end
				if (res.copy_valid !== e.cp) begin
					$display("%0t: copy_valid exp %0d got %0d", $time, e.cp, res.copy_valid);
					n_fail++;
				end
				if (res.window_length !== e.len) begin
					$display("%0t: window_length exp %0d got %0d", $time, e.len,
						res.window_length);
					n_fail++;
				end
				if (res.error_code !== e.err) begin
					$display("%0t: error_code exp %0d got %0d", $time, e.err,
						res.error_code);
					n_fail++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if (!arst_n || (pix.valid && pix.ready) || (res.valid && res.ready)
				|| (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, idle_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic stim_row_t mk_row(input int ph, input int col, input int row,
			input bit fixed, input pix_res_t exp);
		stim_row_t t;
		t.phase = ph;
		t.col = COLW'(col);
		t.row = ROWW'(row);
		t.fixed = fixed;
		t.exp = exp;
		return t;
	endfunction

	initial begin
		geom_t    g;
		pix_res_t zero_len, bad_range, none;
		int       cur, n_items;
		n_fail = 0; n_in = 0; n_out = 0; n_copy = 0; n_err = 0; n_cfg = 0; n_phase = 0;
		idle_cycles = 0;
		stim_done = 1'b0;
		arst_n = 1'b0;
		cfg.valid = 1'b0; cfg.addr = '0; cfg.data = '0;
		pix.valid = 1'b0; pix.out_col = '0; pix.out_row = '0;
		geo = '{sx: '0, sy: '0, ex: '0, ey: '0, ww: 1, nw: MAX_DIM, nh: MAX_DIM};

		zero_len = '0; zero_len.err = ERR_ZERO;
		bad_range = '0; bad_range.err = ERR_RANGE;
		none = '0;

		// phase 0: reset values, degenerate line
		phase_geo.push_back(geo);
		// phase 1: end point beyond the image
		phase_geo.push_back('{sx: '0, sy: '0, ex: 200 << 8, ey: 10 << 8, ww: 4,
			nw: 100, nh: 100});
		// phase 2: saturated sizes, longest diagonal line
		phase_geo.push_back('{sx: '0, sy: '0, ex: 21'h100000, ey: 21'h100000,
			ww: 13'h1fff, nw: 13'h1fff, nh: 13'h1fff});
		// phase 3: small horizontal line
		phase_geo.push_back('{sx: 2 << 8, sy: 8 << 8, ex: 14 << 8, ey: 8 << 8, ww: 4,
			nw: 16, nh: 16});
		// phase 4: reversed oblique line, fractional end points
		phase_geo.push_back('{sx: 21'h0e80, sy: 21'h0340, ex: 21'h0120, ey: 21'h0c10,
			ww: 3, nw: 16, nh: 16});

		stim_tbl.push_back(mk_row(0, 0, 0, 1, zero_len));
		stim_tbl.push_back(mk_row(0, 8191, 4095, 1, zero_len));
		stim_tbl.push_back(mk_row(1, 0, 0, 1, bad_range));
		stim_tbl.push_back(mk_row(1, 8191, 4095, 1, bad_range));
		stim_tbl.push_back(mk_row(1, 3, 1, 1, bad_range));
		stim_tbl.push_back(mk_row(2, 0, 0, 0, none));
		stim_tbl.push_back(mk_row(2, 8191, 4095, 0, none));
		stim_tbl.push_back(mk_row(2, 5792, 2000, 0, none));
		stim_tbl.push_back(mk_row(2, 100, 4095, 0, none));
		stim_tbl.push_back(mk_row(3, 0, 0, 0, none));
		stim_tbl.push_back(mk_row(3, 11, 3, 0, none));
		stim_tbl.push_back(mk_row(3, 12, 0, 0, none));
		stim_tbl.push_back(mk_row(3, 0, 4, 0, none));
		stim_tbl.push_back(mk_row(3, 6, 2, 0, none));
		stim_tbl.push_back(mk_row(3, 4096, 2048, 0, none));
		stim_tbl.push_back(mk_row(4, 0, 0, 0, none));
		stim_tbl.push_back(mk_row(4, 5, 1, 0, none));
		stim_tbl.push_back(mk_row(4, 9, 2, 0, none));
		stim_tbl.push_back(mk_row(4, 10, 3, 0, none));
		stim_tbl.push_back(mk_row(4, 2730, 1365, 0, none));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur = 0;
		foreach (stim_tbl[i]) begin
			if (stim_tbl[i].phase != cur) begin
				cur = stim_tbl[i].phase;
				apply_geom(phase_geo[cur]);
			end
			send_pixel(stim_tbl[i].col, stim_tbl[i].row, stim_tbl[i].fixed,
				stim_tbl[i].exp);
		end

		// random settings, each followed by a burst of pixels
		n_items = 0;
		while (n_items < 730) begin
			int burst, lim_c, lim_r;
			pix_res_t probe;
			rand_geom(g);
			apply_geom(g);
			probe = map_pixel('0, '0);
			lim_c = (probe.len + 3 > 8191) ? 8191 : probe.len + 3;
			lim_r = (clamp_dim(g.ww) + 2 > 4095) ? 4095 : int'(clamp_dim(g.ww)) + 2;
			burst = $urandom_range(15, 60);
			repeat (burst) begin
				if ($urandom_range(0, 9) == 0)
					send_pixel(COLW'($urandom), ROWW'($urandom), 0, none);
				else
					send_pixel(COLW'($urandom_range(0, lim_c)),
						ROWW'($urandom_range(0, lim_r)), 0, none);
			end
			n_items += burst;
		end
		pix.valid <= 1'b0;

		while (pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("ran %0d pixels over %0d register settings (%0d writes)", n_in, n_phase,
			n_cfg);
		$display("results: %0d copied, %0d with error code, %0d mismatches", n_copy,
			n_err, n_fail);
		if (n_fail == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
